FILE: design/esd_pkg.sv
package esd_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ESC   = 8'h1B;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_DQ    = 8'h22;
    localparam logic [7:0] CHAR_SQ    = 8'h27;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CTRL_MASK  = 8'h1F;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    // Results held per item
    localparam int RES_DEPTH = 3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       last;
    } esd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       done_res;
        logic [7:0] total_length;
    } esd_out_t;

    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_NORMAL = 7'b0000010,
        PH_ESC    = 7'b0000100,
        PH_CARET  = 7'b0001000,
        PH_OCT1   = 7'b0010000,
        PH_OCT2   = 7'b0100000,
        PH_STOP   = 7'b1000000
    } phase_t;

    // Outcome of an ordinary character
    typedef struct packed {
        phase_t phase;
        logic   emit;
    } plain_t;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == COUNT_MAX) ? v : v + 8'd1;
    endfunction

    function automatic plain_t plain_step(input logic [7:0] c);
        plain_t p;
        p.emit  = 1'b0;
        p.phase = PH_NORMAL;
        if (c == CHAR_BSL) begin
            p.phase = PH_ESC;
        end else if (c == CHAR_CARET) begin
            p.phase = PH_CARET;
        end else if (c == CHAR_DQ) begin
            p.phase = PH_STOP;
        end else begin
            p.emit = 1'b1;
        end
        return p;
    endfunction

endpackage

FILE: design/escape_string_decoder_unit.sv
// The first result of an item is registered and offered in the cycle after the item
// is accepted. Throughput: one item per cycle while each item yields at most one
// result and each result is taken; an item yielding k results (up to 3) holds the
// input until the single result port has drained the three-entry result buffer to
// its last entry, one entry per cycle while m_ready is high. Reset (aresetn low,
// synchronous) returns the decoder to start of string and empties the result buffer.
module escape_string_decoder_unit
    import esd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  esd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output esd_out_t m_data
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  octal_reg, octal_next;
    logic [7:0]  count_reg, count_next;
    logic [1:0]  rem_reg, rem_next;
    esd_out_t    buf_reg [RES_DEPTH];
    esd_out_t    res_v   [RES_DEPTH];
    logic [1:0]  n_v;
    logic        fin_v;
    logic [7:0]  c;
    plain_t      ps;
    logic        accept;
    logic        pop;

    assign c      = s_data.in_char;
    assign ps     = plain_step(c);
    assign m_valid = (rem_reg != 2'd0);
    assign m_data  = buf_reg[0];
    assign s_ready = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_ready);
    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    // Decode one character into up to three results
    always_comb begin
        phase_next = phase_reg;
        octal_next = octal_reg;
        count_next = count_reg;
        n_v        = 2'd0;
        fin_v      = (c == CHAR_NUL) || s_data.last;
        for (int i = 0; i < RES_DEPTH; i++) begin
            res_v[i] = '0;
        end

        if (c != CHAR_NUL) begin
            case (phase_reg)
                PH_START: begin
                    if (c == CHAR_DQ) begin
                        phase_next = PH_NORMAL;
                    end else begin
                        if (ps.emit) begin
                            count_next = sat_inc(count_next);
                            res_v[n_v] = '{c, 1'b1, 1'b0, count_next};
                            n_v = n_v + 2'd1;
                        end
                        phase_next = ps.phase;
                    end
                end
                PH_ESC: begin
                    if (c == CHAR_E || c == CHAR_N || c == CHAR_BSL || c == CHAR_DQ ||
                        c == CHAR_SQ) begin
                        count_next = sat_inc(count_next);
                        res_v[n_v] = '{(c == CHAR_E) ? CHAR_ESC :
                                       (c == CHAR_N) ? CHAR_LF : c,
                                       1'b1, 1'b0, count_next};
                        n_v = n_v + 2'd1;
                        phase_next = PH_NORMAL;
                    end else if (is_oct(c)) begin
                        octal_next = {5'd0, c[2:0]};
                        phase_next = PH_OCT1;
                    end else begin
                        if (ps.emit) begin
                            count_next = sat_inc(count_next);
                            res_v[n_v] = '{c, 1'b1, 1'b0, count_next};
                            n_v = n_v + 2'd1;
                        end
                        phase_next = ps.phase;
                    end
                end
                PH_CARET: begin
                    count_next = sat_inc(count_next);
                    res_v[n_v] = '{c & CTRL_MASK, 1'b1, 1'b0, count_next};
                    n_v = n_v + 2'd1;
                    phase_next = PH_NORMAL;
                end
                PH_OCT1, PH_OCT2: begin
                    if (is_oct(c)) begin
                        // value * 8 + digit, mod 256
                        octal_next = {octal_reg[4:0], c[2:0]};
                        if (phase_reg == PH_OCT1) begin
                            phase_next = PH_OCT2;
                        end else begin
                            count_next = sat_inc(count_next);
                            res_v[n_v] = '{octal_next, 1'b1, 1'b0, count_next};
                            n_v = n_v + 2'd1;
                            phase_next = PH_NORMAL;
                        end
                    end else begin
                        // flush the value, then take the character as ordinary
                        count_next = sat_inc(count_next);
                        res_v[n_v] = '{octal_reg, 1'b1, 1'b0, count_next};
                        n_v = n_v + 2'd1;
                        if (ps.emit) begin
                            count_next = sat_inc(count_next);
                            res_v[n_v] = '{c, 1'b1, 1'b0, count_next};
                            n_v = n_v + 2'd1;
                        end
                        phase_next = ps.phase;
                    end
                end
                PH_STOP: begin
                    phase_next = PH_STOP;
                end
                default: begin
                    if (ps.emit) begin
                        count_next = sat_inc(count_next);
                        res_v[n_v] = '{c, 1'b1, 1'b0, count_next};
                        n_v = n_v + 2'd1;
                    end
                    phase_next = ps.phase;
                end
            endcase
        end

        // End of string: flush pending octal, then the length marker
        if (fin_v) begin
            if (phase_next == PH_OCT1 || phase_next == PH_OCT2) begin
                count_next = sat_inc(count_next);
                res_v[n_v] = '{octal_next, 1'b1, 1'b0, count_next};
                n_v = n_v + 2'd1;
            end
            res_v[n_v] = '{8'd0, 1'b0, 1'b1, count_next};
            n_v = n_v + 2'd1;
            phase_next = PH_START;
            octal_next = 8'd0;
            count_next = 8'd0;
        end
    end

    // Remaining-result count
    always_comb begin
        rem_next = rem_reg;
        if (accept) begin
            rem_next = n_v;
        end else if (pop) begin
            rem_next = rem_reg - 2'd1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            octal_reg <= 8'd0;
            count_reg <= 8'd0;
            rem_reg   <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            if (accept) begin
                phase_reg <= phase_next;
                octal_reg <= octal_next;
                count_reg <= count_next;
            end
        end
    end

    // Result buffer: load on accept, shift down on pop
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < RES_DEPTH; i++) begin
                buf_reg[i] <= res_v[i];
            end
        end else if (pop) begin
            for (int i = 0; i < RES_DEPTH - 1; i++) begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

endmodule

FILE: design/esd_checker.sv
module esd_checker
    import esd_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input esd_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input esd_out_t m_data
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Nothing offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // End marker carries no byte
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.has_byte && m_data.out_byte == 8'd0)
        else $error("malformed end marker");

    // A byte always counts itself
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.has_byte |-> m_data.total_length != 8'd0 && !m_data.done_res)
        else $error("byte result with zero length");

    // A string terminator always yields at least the end marker
    a_term: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> m_valid)
        else $error("no result after final character");

endmodule

bind escape_string_decoder_unit esd_checker u_esd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/sv/escape_string_decoder_unit_tb.sv
`timescale 1ns / 100ps

module escape_string_decoder_unit_tb;
    import esd_pkg::*;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    esd_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    esd_out_t m_data;

    // Characters waiting to be offered, and decoded results still due
    esd_in_t  pending_items[$];
    esd_out_t decoded_results[$];

    // Traffic shaping, changed only at the falling edge (stall_left counts down in the receiver)
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          sender_hold    = 1'b0;
    bit          long_stall_req = 1'b0;
    int unsigned stall_left     = 0;

    // Set by the receiver once the long hold-off has started
    bit          long_stall_taken = 1'b0;

    int mismatch_count = 0;

    // Decoder shadow state
    phase_t     dec_phase = PH_START;
    logic [7:0] oct_acc   = '0;
    logic [7:0] emitted   = '0;

    escape_string_decoder_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Decoder prediction
    // ---------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        if (emitted != COUNT_MAX) emitted = emitted + 8'd1;
        decoded_results.push_back(esd_out_t'{out_byte: b, has_byte: 1'b1,
                                             done_res: 1'b0, total_length: emitted});
    endfunction

    // End of string: flush a pending octal value, then the length marker
    function automatic void close_string();
        if (dec_phase == PH_OCT1 || dec_phase == PH_OCT2) push_byte(oct_acc);
        decoded_results.push_back(esd_out_t'{out_byte: 8'd0, has_byte: 1'b0,
                                             done_res: 1'b1, total_length: emitted});
        dec_phase = PH_START;
        oct_acc   = '0;
        emitted   = '0;
    endfunction

    function automatic void decode_plain(input logic [7:0] c);
        if (c == CHAR_BSL) begin
            dec_phase = PH_ESC;
        end else if (c == CHAR_CARET) begin
            dec_phase = PH_CARET;
        end else if (c == CHAR_DQ) begin
            dec_phase = PH_STOP;
        end else begin
            push_byte(c);
            dec_phase = PH_NORMAL;
        end
    endfunction

    function automatic void decode_item(input esd_in_t it);
        logic [7:0] c;
        logic       is_digit;
        c = it.in_char;
        if (c == CHAR_NUL) begin
            close_string();
            return;
        end
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
        case (dec_phase)
            PH_START: begin
                // opening quote is skipped
                if (c == CHAR_DQ) dec_phase = PH_NORMAL;
                else decode_plain(c);
            end
            PH_ESC: begin
                if (c == CHAR_E) begin
                    push_byte(CHAR_ESC);
                    dec_phase = PH_NORMAL;
                end else if (c == CHAR_N) begin
                    push_byte(CHAR_LF);
                    dec_phase = PH_NORMAL;
                end else if (c == CHAR_BSL || c == CHAR_DQ || c == CHAR_SQ) begin
                    push_byte(c);
                    dec_phase = PH_NORMAL;
                end else if (is_digit) begin
                    oct_acc   = {5'b0, c[2:0]};
                    dec_phase = PH_OCT1;
                end else begin
                    decode_plain(c);
                end
            end
            PH_CARET: begin
                push_byte(c & CTRL_MASK);
                dec_phase = PH_NORMAL;
            end
            PH_OCT1, PH_OCT2: begin
                if (is_digit) begin
                    oct_acc = {oct_acc[4:0], c[2:0]};
                    if (dec_phase == PH_OCT1) begin
                        dec_phase = PH_OCT2;
                    end else begin
                        push_byte(oct_acc);
                        dec_phase = PH_NORMAL;
                    end
                end else begin
                    // octal cut short: value first, then this character
                    push_byte(oct_acc);
                    decode_plain(c);
                end
            end
            PH_STOP: ;
            default: decode_plain(c);
        endcase
        if (it.last) close_string();
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void push_item(input logic [7:0] c, input logic l);
        pending_items.push_back(esd_in_t'{in_char: c, last: l});
    endfunction

    function automatic void queue_text(input string s, input bit with_last);
        for (int i = 0; i < s.len(); i++) begin
            push_item(s[i], with_last && (i == s.len() - 1));
        end
    endfunction

    // Nonzero character with no special meaning of its own
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CHAR_BSL || c == CHAR_CARET || c == CHAR_DQ);
        return c;
    endfunction

    // Mostly well-formed escape strings, some raw noise
    function automatic void queue_mixed(input int target);
        logic [7:0] str[$];
        int         count;
        bit         with_last;
        count = 0;
        while (count < target) begin
            str.delete();
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    push_item(8'($urandom_range(255)), $urandom_range(7) == 0);
                    count++;
                end
            end else begin
                if ($urandom_range(3) == 0) str.push_back(CHAR_DQ);
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(9))
                        0, 1, 2: str.push_back(plain_char());
                        3: begin
                            str.push_back(CHAR_BSL);
                            str.push_back($urandom_range(1) ? CHAR_E : CHAR_N);
                        end
                        4: begin
                            str.push_back(CHAR_BSL);
                            case ($urandom_range(2))
                                0: str.push_back(CHAR_BSL);
                                1: str.push_back(CHAR_DQ);
                                default: str.push_back(CHAR_SQ);
                            endcase
                        end
                        5: begin
                            str.push_back(CHAR_BSL);
                            repeat ($urandom_range(1, 3))
                                str.push_back(CHAR_ZERO | 8'($urandom_range(7)));
                        end
                        6: begin
                            str.push_back(CHAR_CARET);
                            str.push_back(8'($urandom_range(1, 255)));
                        end
                        7: begin
                            str.push_back(CHAR_BSL);
                            str.push_back(plain_char());
                        end
                        8: begin
                            // stop quote, then characters to be ignored
                            str.push_back(CHAR_DQ);
                            repeat ($urandom_range(3))
                                str.push_back(8'($urandom_range(1, 255)));
                        end
                        default: str.push_back(CHAR_ZERO | 8'($urandom_range(7)));
                    endcase
                end
                // dangling caret or backslash at the end
                if ($urandom_range(5) == 0)
                    str.push_back($urandom_range(1) ? CHAR_CARET : CHAR_BSL);
                with_last = (str.size() != 0) && ($urandom_range(1) == 1);
                foreach (str[i]) push_item(str[i], with_last && (i == str.size() - 1));
                if (!with_last) push_item(CHAR_NUL, 1'($urandom_range(1)));
                count += str.size() + (with_last ? 0 : 1);
            end
        end
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || decoded_results.size() != 0)
            @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued items, holds each until accepted
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (long_stall_req && !long_stall_taken) begin
            long_stall_taken <= 1'b1;
            stall_left       <= 300;
            m_ready          <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on accepted input, check accepted results
    always @(posedge aclk) begin : monitor
        esd_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) decode_item(s_data);
            if (m_valid && m_ready) begin
                if (decoded_results.size() == 0) begin
                    $error("unexpected result: out_byte %0d has_byte %0b done_res %0b len %0d",
                           m_data.out_byte, m_data.has_byte, m_data.done_res,
                           m_data.total_length);
                    mismatch_count++;
                end else begin
                    want = decoded_results.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0d, got %0d",
                               want.out_byte, m_data.out_byte);
                        mismatch_count++;
                    end
                    if (m_data.has_byte !== want.has_byte) begin
                        $error("has_byte: expected %0b, got %0b",
                               want.has_byte, m_data.has_byte);
                        mismatch_count++;
                    end
                    if (m_data.done_res !== want.done_res) begin
                        $error("done_res: expected %0b, got %0b",
                               want.done_res, m_data.done_res);
                        mismatch_count++;
                    end
                    if (m_data.total_length !== want.total_length) begin
                        $error("total_length: expected %0d, got %0d",
                               want.total_length, m_data.total_length);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every escape form, octal extremes, dangling marks, stop quote
        queue_text("\"A\\E\\n\\\\", 1'b0);
        push_item(CHAR_BSL, 1'b0);
        push_item(CHAR_SQ, 1'b0);
        queue_text("\\\"\\377\\5\\q^\"\\1", 1'b0);
        push_item(CHAR_NUL, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CHAR_BSL, 1'b1);
        push_item(CHAR_CARET, 1'b1);
        queue_text("a\"Z", 1'b0);
        push_item(CHAR_NUL, 1'b1);
        wait_drained();

        // No idling; long receiver hold-off while the sender keeps going,
        // then one string long enough to saturate the length
        queue_mixed(18);
        long_stall_req = 1'b1;
        for (int i = 0; i < 260; i++) push_item(plain_char(), i == 259);
        wait_drained();

        // Sender mostly idle
        send_idle_pct = 70;
        queue_mixed(18);
        wait_drained();

        // Receiver mostly stalling, with one sender pause until all results are in
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        queue_mixed(18);
        while (pending_items.size() > 9) @(negedge aclk);
        sender_hold = 1'b1;
        while (s_valid || decoded_results.size() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
        sender_hold = 1'b0;
        wait_drained();

        // Both sides idling
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        queue_mixed(18);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
design/esd_pkg.sv
design/escape_string_decoder_unit.sv
design/esd_checker.sv
tb/sv/escape_string_decoder_unit_tb.sv
